// File: rtl/hpdc_pkg.sv
// Shared types, constant tables and the divider split for the HDMI PLL divider search.
// No dependencies; imported by every other file in rtl/.
package hpdc_pkg;

    localparam int PCLK_W = 20;
    localparam int DIV_W  = 7;
    localparam int X_W    = 27;   // pixel clock times divider
    localparam int BX_W   = 21;   // a fitting product stays below 2^21
    localparam int DIFF_W = 17;   // a fitting distance from centre is below 115200
    localparam int RCP_W  = 11;
    localparam int DEV_W  = 10;
    localparam int K_W    = 8;
    localparam int INT_W  = 9;
    localparam int REM_W  = 13;
    localparam int FRAC_W = 15;
    localparam int FP_W   = 39;
    localparam int Y_W    = REM_W + 9;

    localparam int N_EVEN = 36;
    localparam int N_ODD  = 7;
    localparam int N_CTR  = 3;
    localparam int IDX_W  = $clog2(N_EVEN);
    localparam int OIDX_W = $clog2(N_ODD);
    localparam int CTR_W  = 2;

    typedef logic [DIV_W-1:0] t_div;

    localparam t_div EVEN_DIVS [N_EVEN] = '{
        7'd4,  7'd6,  7'd8,  7'd10, 7'd12, 7'd14, 7'd16, 7'd18, 7'd20, 7'd24, 7'd28, 7'd30,
        7'd32, 7'd36, 7'd40, 7'd42, 7'd44, 7'd48, 7'd52, 7'd54, 7'd56, 7'd60, 7'd64, 7'd66,
        7'd68, 7'd70, 7'd72, 7'd76, 7'd78, 7'd80, 7'd84, 7'd88, 7'd90, 7'd92, 7'd96, 7'd98
    };
    localparam t_div ODD_DIVS [N_ODD] = '{7'd3, 7'd5, 7'd7, 7'd9, 7'd15, 7'd21, 7'd35};

    // Centres scaled down by 5000 (AFE factor): centre = K * 10000, so dev = |x - centre| / K.
    localparam logic [BX_W-1:0]   CTR_X   [N_CTR] = '{21'd1680000, 21'd1800000, 21'd1920000};
    localparam logic [K_W-1:0]    CTR_K   [N_CTR] = '{8'd168, 8'd180, 8'd192};
    localparam logic [DIFF_W-1:0] LIM_LO  [N_CTR] = '{17'd100800, 17'd108000, 17'd115200};
    localparam logic [DIFF_W-1:0] LIM_HI  [N_CTR] = '{17'd16800, 17'd18000, 17'd19200};
    localparam logic [CTR_W-1:0]  CTR_CODE[N_CTR] = '{2'd3, 2'd1, 2'd0};

    // floor(2^s / K) reciprocals; s chosen above the numerator range so one fix-up suffices
    localparam int DEV_SHIFT = 18;
    localparam logic [RCP_W-1:0] DEV_RECIP [N_CTR] = '{11'd1560, 11'd1456, 11'd1365};
    localparam logic [DEV_W-1:0] DEV_START = 10'd600;

    localparam int INT_SHIFT  = 22;
    localparam logic [12:0] INT_DIV   = 13'd4800;
    localparam logic [9:0]  INT_RECIP = 10'd873;
    localparam int FRAC_SHIFT = 23;
    localparam logic [6:0]  FRAC_DIV   = 7'd75;
    localparam logic [16:0] FRAC_RECIP = 17'd111848;

    localparam logic [1:0] KCODE_NONE = 2'd0;
    localparam logic [1:0] KCODE_K1   = 2'd3;
    localparam logic [1:0] KCODE_K2   = 2'd1;
    localparam logic [1:0] KCODE_K3   = 2'd2;
    localparam logic [2:0] PCODE_NONE = 3'd0;
    localparam logic [2:0] PCODE_P2   = 3'd1;
    localparam logic [2:0] PCODE_P3   = 3'd2;
    localparam logic [2:0] PCODE_P5   = 3'd3;
    localparam logic [2:0] PCODE_P7   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EVEN, ST_EVEN_DRAIN, ST_ODD, ST_ODD_DRAIN,
        ST_INT_MUL, ST_INT_FIX, ST_FRAC_MUL, ST_FRAC_FIX, ST_DONE
    } t_state;

    typedef struct packed {
        logic             clear;
        logic             issue;
        logic             odd;
        logic [CTR_W-1:0] ctr;
        logic [IDX_W-1:0] idx;
        logic             int_mul;
        logic             int_fix;
        logic             frac_mul;
        logic             frac_fix;
    } t_cmd;

    typedef struct packed {
        logic pipe_empty;
        logic hit;
    } t_status;

    typedef struct packed {
        logic [7:0] qratio;
        logic       qen;
        logic [1:0] kcode;
        logic [2:0] pcode;
    } t_split;

    function automatic t_split split_div(input t_div d);
        logic [5:0] h;
        logic [2:0] p0;
        logic [5:0] p1;
        logic [2:0] p2;
        t_split     s;
        h  = d[6:1];
        p0 = '0;
        p1 = '0;
        p2 = '0;
        if (d[0]) begin
            unique case (d)
                7'd3:    begin p0 = 3'd3; p1 = 6'd1; p2 = 3'd1; end
                7'd9:    begin p0 = 3'd3; p1 = 6'd1; p2 = 3'd3; end
                7'd5:    begin p0 = 3'd5; p1 = 6'd1; p2 = 3'd1; end
                7'd7:    begin p0 = 3'd7; p1 = 6'd1; p2 = 3'd1; end
                7'd15:   begin p0 = 3'd3; p1 = 6'd1; p2 = 3'd5; end
                7'd21:   begin p0 = 3'd7; p1 = 6'd1; p2 = 3'd3; end
                7'd35:   begin p0 = 3'd7; p1 = 6'd1; p2 = 3'd5; end
                default: begin p0 = '0;   p1 = '0;   p2 = '0;   end
            endcase
        end else if (h == 6'd1 || h == 6'd2 || h == 6'd3 || h == 6'd5) begin
            p0 = 3'd2;
            p1 = 6'd1;
            p2 = h[2:0];
        end else if (!h[0]) begin
            p0 = 3'd2;
            p1 = {1'b0, h[5:1]};
            p2 = 3'd2;
        end else begin
            // odd half: factor 3 takes precedence over 7
            unique case (h)
                6'd9:    begin p0 = 3'd3; p1 = 6'd3;  end
                6'd15:   begin p0 = 3'd3; p1 = 6'd5;  end
                6'd21:   begin p0 = 3'd3; p1 = 6'd7;  end
                6'd27:   begin p0 = 3'd3; p1 = 6'd9;  end
                6'd33:   begin p0 = 3'd3; p1 = 6'd11; end
                6'd39:   begin p0 = 3'd3; p1 = 6'd13; end
                6'd45:   begin p0 = 3'd3; p1 = 6'd15; end
                6'd7:    begin p0 = 3'd7; p1 = 6'd1;  end
                6'd35:   begin p0 = 3'd7; p1 = 6'd5;  end
                6'd49:   begin p0 = 3'd7; p1 = 6'd7;  end
                default: begin p0 = '0;   p1 = '0;    end
            endcase
            p2 = (p0 != '0) ? 3'd2 : '0;
        end
        s.qen    = (p1 > 6'd1);
        s.qratio = s.qen ? {2'b00, p1} : '0;
        unique case (p2)
            3'd1:    s.kcode = KCODE_K1;
            3'd2:    s.kcode = KCODE_K2;
            3'd3:    s.kcode = KCODE_K3;
            default: s.kcode = KCODE_NONE;
        endcase
        unique case (p0)
            3'd2:    s.pcode = PCODE_P2;
            3'd3:    s.pcode = PCODE_P3;
            3'd5:    s.pcode = PCODE_P5;
            3'd7:    s.pcode = PCODE_P7;
            default: s.pcode = PCODE_NONE;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/hpdc_ctrl.sv
// Sequencer for the divider search: walks centres and divider lists, then the DCO steps.
// Depends on hpdc_pkg.
module hpdc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output logic              o_valid,
    input  hpdc_pkg::t_status i_status,
    output hpdc_pkg::t_cmd    o_cmd
);
    import hpdc_pkg::*;

    t_state           r_state, n_state;
    logic [CTR_W-1:0] r_ctr, n_ctr;
    logic [IDX_W-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ctr   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_ctr   <= n_ctr;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ctr   = r_ctr;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.ctr = r_ctr;
        o_cmd.idx = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.clear = 1'b1;
                    n_ctr   = '0;
                    n_idx   = '0;
                    n_state = ST_EVEN;
                end
            end
            ST_EVEN, ST_ODD: begin
                o_cmd.issue = 1'b1;
                o_cmd.odd   = (r_state == ST_ODD);
                if ((r_state == ST_EVEN && r_idx == IDX_W'(N_EVEN - 1)) ||
                    (r_state == ST_ODD  && r_idx == IDX_W'(N_ODD - 1))) begin
                    n_idx = '0;
                    if (r_ctr == CTR_W'(N_CTR - 1)) begin
                        n_ctr   = '0;
                        n_state = (r_state == ST_EVEN) ? ST_EVEN_DRAIN : ST_ODD_DRAIN;
                    end else begin
                        n_ctr = r_ctr + 1'b1;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_EVEN_DRAIN: begin
                if (i_status.pipe_empty) begin
                    n_state = i_status.hit ? ST_INT_MUL : ST_ODD;
                end
            end
            ST_ODD_DRAIN: begin
                if (i_status.pipe_empty) begin
                    n_state = i_status.hit ? ST_INT_MUL : ST_DONE;
                end
            end
            ST_INT_MUL: begin
                o_cmd.int_mul = 1'b1;
                n_state = ST_INT_FIX;
            end
            ST_INT_FIX: begin
                o_cmd.int_fix = 1'b1;
                n_state = ST_FRAC_MUL;
            end
            ST_FRAC_MUL: begin
                o_cmd.frac_mul = 1'b1;
                n_state = ST_FRAC_FIX;
            end
            ST_FRAC_FIX: begin
                o_cmd.frac_fix = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_DONE);

endmodule

// File: rtl/hpdc_dpath.sv
// Datapath: four-stage candidate pipeline with best tracking, then DCO integer/fraction.
// Depends on hpdc_pkg.
module hpdc_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [hpdc_pkg::PCLK_W-1:0]    i_pixel_clock_khz,
    input  hpdc_pkg::t_cmd                 i_cmd,
    output hpdc_pkg::t_status              o_status,
    output logic                           o_found,
    output logic [hpdc_pkg::DIV_W-1:0]     o_output_divider,
    output logic [hpdc_pkg::CTR_W-1:0]     o_central_freq_sel,
    output logic [hpdc_pkg::INT_W-1:0]     o_dco_integer,
    output logic [hpdc_pkg::FRAC_W-1:0]    o_dco_fraction,
    output logic [7:0]                     o_qdiv_ratio,
    output logic                           o_qdiv_enable,
    output logic [1:0]                     o_kdiv_code,
    output logic [2:0]                     o_pdiv_code
);
    import hpdc_pkg::*;

    logic [PCLK_W-1:0] r_pclk;

    logic              r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic [X_W-1:0]    r_s1_x;
    logic [BX_W-1:0]   r_s2_x, r_s3_x, r_s4_x;
    t_div              r_s1_d, r_s2_d, r_s3_d, r_s4_d;
    logic [CTR_W-1:0]  r_s1_c, r_s2_c, r_s3_c, r_s4_c;
    logic [DIFF_W-1:0] r_s2_diff, r_s3_diff;
    logic [DIFF_W+RCP_W-1:0] r_s3_prod;
    logic [DEV_W-1:0]  r_s4_dev;

    logic              r_hit;
    logic [DEV_W-1:0]  r_best_dev;
    t_div              r_bd;
    logic [CTR_W-1:0]  r_bc;
    logic [BX_W-1:0]   r_bx;

    logic [FP_W-1:0]   r_fprod;
    logic [INT_W-1:0]  r_int;
    logic [REM_W-1:0]  r_rem;
    logic [FRAC_W-1:0] r_frac;

    t_div              s0_d;
    logic              s1_hi, s1_ok;
    logic [X_W-1:0]    s1_cx, s1_diff;
    logic [DEV_W-1:0]  s3_q;
    logic [DIFF_W-1:0] s3_r;
    logic [INT_W-1:0]  f_iq;
    logic [BX_W-1:0]   f_ir;
    logic [Y_W-1:0]    f_y;
    logic [FRAC_W-1:0] f_fq;
    logic [Y_W-1:0]    f_fr;
    t_split            sp;

    assign s0_d = i_cmd.odd ? ODD_DIVS[i_cmd.idx[OIDX_W-1:0]] : EVEN_DIVS[i_cmd.idx];

    always_comb begin
        s1_cx   = X_W'(CTR_X[r_s1_c]);
        s1_hi   = (r_s1_x > s1_cx);
        s1_diff = s1_hi ? (r_s1_x - s1_cx) : (s1_cx - r_s1_x);
        s1_ok   = s1_hi ? (s1_diff < X_W'(LIM_HI[r_s1_c]))
                        : (s1_diff < X_W'(LIM_LO[r_s1_c]));
    end

    // reciprocal quotient may be one short
    always_comb begin
        s3_q = r_s3_prod[DEV_SHIFT +: DEV_W];
        s3_r = r_s3_diff - DIFF_W'(DIFF_W'(s3_q) * DIFF_W'(CTR_K[r_s3_c]));
    end

    always_comb begin
        f_iq = r_fprod[INT_SHIFT +: INT_W];
        f_ir = r_bx - BX_W'(BX_W'(f_iq) * BX_W'(INT_DIV));
        f_y  = {r_rem, 9'b0};
        f_fq = r_fprod[FRAC_SHIFT +: FRAC_W];
        f_fr = f_y - Y_W'(Y_W'(f_fq) * Y_W'(FRAC_DIV));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_hit  <= 1'b0;
            r_best_dev <= DEV_START;
        end else begin
            r_s1_v <= i_cmd.issue;
            r_s2_v <= r_s1_v & s1_ok;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            if (i_cmd.clear) begin
                r_hit      <= 1'b0;
                r_best_dev <= DEV_START;
            end else if (r_s4_v && r_s4_dev <= r_best_dev) begin
                r_hit      <= 1'b1;
                r_best_dev <= r_s4_dev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_pclk <= i_pixel_clock_khz;
        end
        r_s1_x <= X_W'(r_pclk) * X_W'(s0_d);
        r_s1_d <= s0_d;
        r_s1_c <= i_cmd.ctr;

        r_s2_diff <= s1_diff[DIFF_W-1:0];
        r_s2_x    <= r_s1_x[BX_W-1:0];
        r_s2_d    <= r_s1_d;
        r_s2_c    <= r_s1_c;

        r_s3_prod <= (DIFF_W+RCP_W)'(r_s2_diff) * (DIFF_W+RCP_W)'(DEV_RECIP[r_s2_c]);
        r_s3_diff <= r_s2_diff;
        r_s3_x    <= r_s2_x;
        r_s3_d    <= r_s2_d;
        r_s3_c    <= r_s2_c;

        r_s4_dev <= (s3_r >= DIFF_W'(CTR_K[r_s3_c])) ? s3_q + 1'b1 : s3_q;
        r_s4_x   <= r_s3_x;
        r_s4_d   <= r_s3_d;
        r_s4_c   <= r_s3_c;

        if (!i_cmd.clear && r_s4_v && r_s4_dev <= r_best_dev) begin
            r_bd <= r_s4_d;
            r_bc <= r_s4_c;
            r_bx <= r_s4_x;
        end

        if (i_cmd.int_mul) begin
            r_fprod <= FP_W'(r_bx) * FP_W'(INT_RECIP);
        end else if (i_cmd.frac_mul) begin
            r_fprod <= FP_W'(f_y) * FP_W'(FRAC_RECIP);
        end
        if (i_cmd.int_fix) begin
            if (f_ir >= BX_W'(INT_DIV)) begin
                r_int <= f_iq + 1'b1;
                r_rem <= REM_W'(f_ir - BX_W'(INT_DIV));
            end else begin
                r_int <= f_iq;
                r_rem <= REM_W'(f_ir);
            end
        end
        if (i_cmd.frac_fix) begin
            r_frac <= (f_fr >= Y_W'(FRAC_DIV)) ? f_fq + 1'b1 : f_fq;
        end
    end

    assign o_status.pipe_empty = !(r_s1_v | r_s2_v | r_s3_v | r_s4_v);
    assign o_status.hit        = r_hit;

    assign sp = split_div(r_bd);

    assign o_found            = r_hit;
    assign o_output_divider   = r_hit ? r_bd : '0;
    assign o_central_freq_sel = r_hit ? CTR_CODE[r_bc] : '0;
    assign o_dco_integer      = r_hit ? r_int : '0;
    assign o_dco_fraction     = r_hit ? r_frac : '0;
    assign o_qdiv_ratio       = r_hit ? sp.qratio : '0;
    assign o_qdiv_enable      = r_hit ? sp.qen : 1'b0;
    assign o_kdiv_code        = r_hit ? sp.kcode : '0;
    assign o_pdiv_code        = r_hit ? sp.pcode : '0;

endmodule

// File: rtl/hdmi_pll_divider_calc_top.sv
// Top level of the HDMI PLL divider search: sequencer plus datapath.
// Depends on hpdc_pkg, hpdc_ctrl and hpdc_dpath.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  item in  | start & !busy         | i_pixel_clock_khz
//  item out | o_valid, one cycle    | o_found, o_output_divider, ... o_pdiv_code
//
// One candidate enters the four-stage deviation pipeline per cycle (108 even, 21 odd);
// each list drains until its last fitting candidate has left the pipeline, and the odd
// list is searched only when no even divider fits. If a candidate fitted, an integer
// reciprocal multiply and fix-up, then a fraction multiply and fix-up, form the DCO
// integer and fraction.
// Reset is synchronous, active low, and returns the sequencer to idle.
// Results cannot be stalled; busy drops the cycle after o_valid.
module hdmi_pll_divider_calc_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [hpdc_pkg::PCLK_W-1:0]   i_pixel_clock_khz,
    output logic                          o_valid,
    output logic                          o_found,
    output logic [hpdc_pkg::DIV_W-1:0]    o_output_divider,
    output logic [hpdc_pkg::CTR_W-1:0]    o_central_freq_sel,
    output logic [hpdc_pkg::INT_W-1:0]    o_dco_integer,
    output logic [hpdc_pkg::FRAC_W-1:0]   o_dco_fraction,
    output logic [7:0]                    o_qdiv_ratio,
    output logic                          o_qdiv_enable,
    output logic [1:0]                    o_kdiv_code,
    output logic [2:0]                    o_pdiv_code
);
    import hpdc_pkg::*;

    t_cmd    cmd;
    t_status status;

    hpdc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_valid  (o_valid),
        .i_status (status),
        .o_cmd    (cmd)
    );

    hpdc_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_pixel_clock_khz  (i_pixel_clock_khz),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_found            (o_found),
        .o_output_divider   (o_output_divider),
        .o_central_freq_sel (o_central_freq_sel),
        .o_dco_integer      (o_dco_integer),
        .o_dco_fraction     (o_dco_fraction),
        .o_qdiv_ratio       (o_qdiv_ratio),
        .o_qdiv_enable      (o_qdiv_enable),
        .o_kdiv_code        (o_kdiv_code),
        .o_pdiv_code        (o_pdiv_code)
    );

endmodule
